// File: rtl/owrs_pkg.sv
package owrs_pkg;

   localparam int unsigned CMD_W = 8;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned ROM_CODE_W = 64;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CMD_W-1:0] SEARCH_COMMAND_RESET = 8'hF0;
   localparam logic [COUNT_W-1:0] DEVICE_LIMIT_RESET = 8'd2;

   typedef enum logic [1:0] {
      OP_BEGIN      = 2'd0,
      OP_RESET_DONE = 2'd1,
      OP_BIT_PAIR   = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEARCH_COMMAND = 1'b0,
      CSR_DEVICE_LIMIT   = 1'b1
   } csr_index_type;

   // One input event as held in the input stage.
   typedef struct packed {
      logic [1:0] op;
      logic       presence;
      logic       id_bit;
      logic       cmpl_bit;
   } evt_type;

   // One result beat as held in the output stage.
   typedef struct packed {
      logic                  send_command;
      logic [CMD_W-1:0]      command_byte;
      logic                  write_valid;
      logic                  write_bit;
      logic                  rom_valid;
      logic [ROM_CODE_W-1:0] found_code;
      logic [COUNT_W-1:0]    device_number;
      logic                  search_done;
      logic                  bus_error;
      logic [COUNT_W-1:0]    devices_found;
   } rslt_type;

endpackage

// File: rtl/owrs_if.sv
interface owrs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic       presence;
   logic       id_bit;
   logic       cmpl_bit;

   modport source (output valid, op, presence, id_bit, cmpl_bit, input ready);
   modport sink (input valid, op, presence, id_bit, cmpl_bit, output ready);
endinterface

interface owrs_rsp_if;
   logic        valid;
   logic        ready;
   logic        send_command;
   logic [7:0]  command_byte;
   logic        write_valid;
   logic        write_bit;
   logic        rom_valid;
   logic [63:0] found_code;
   logic [7:0]  device_number;
   logic        search_done;
   logic        bus_error;
   logic [7:0]  devices_found;

   modport source (output valid, send_command, command_byte, write_valid, write_bit,
                   rom_valid, found_code, device_number, search_done, bus_error,
                   devices_found, input ready);
   modport sink (input valid, send_command, command_byte, write_valid, write_bit,
                 rom_valid, found_code, device_number, search_done, bus_error,
                 devices_found, output ready);
endinterface

// File: rtl/owrs_step.sv
module owrs_step
   import owrs_pkg::*;
#(
   parameter int unsigned ROM_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  evt_type            evt,
   input  logic [CMD_W-1:0]   search_command,
   input  logic [COUNT_W-1:0] device_limit,
   output rslt_type           rslt
);

   localparam int unsigned POS_W = $clog2(ROM_BITS + 1);
   localparam int unsigned IDX_W = $clog2(ROM_BITS);

   logic [ROM_BITS-1:0] rom_bits_ff, rom_bits_in;
   logic [POS_W-1:0]    last_mismatch_ff, last_mismatch_in;
   logic [POS_W-1:0]    last_zero_pos_ff, last_zero_pos_in;
   logic [POS_W-1:0]    bit_position_ff, bit_position_in;
   logic [COUNT_W-1:0]  found_count_ff, found_count_in;
   logic                finished_ff, finished_in;
   logic                in_pass_ff, in_pass_in;

   logic [POS_W-1:0]    pos_minus1;
   logic [IDX_W-1:0]    pos_idx;
   logic [COUNT_W-1:0]  limit;
   logic                dir;

   assign pos_minus1 = bit_position_ff - POS_W'(1);
   assign pos_idx    = pos_minus1[IDX_W-1:0];
   // A limit of zero acts as a limit of one.
   assign limit      = (device_limit == '0) ? COUNT_W'(1) : device_limit;

   always_comb begin
      rom_bits_in      = rom_bits_ff;
      last_mismatch_in = last_mismatch_ff;
      last_zero_pos_in = last_zero_pos_ff;
      bit_position_in  = bit_position_ff;
      found_count_in   = found_count_ff;
      finished_in      = finished_ff;
      in_pass_in       = in_pass_ff;
      rslt             = '0;
      dir              = 1'b0;

      case (evt.op)
         OP_BEGIN: begin
            rom_bits_in      = '0;
            last_mismatch_in = '0;
            last_zero_pos_in = '0;
            bit_position_in  = POS_W'(1);
            found_count_in   = '0;
            finished_in      = 1'b0;
            in_pass_in       = 1'b0;
         end
         OP_RESET_DONE: begin
            if (!finished_ff) begin
               if (!evt.presence) begin
                  finished_in      = 1'b1;
                  in_pass_in       = 1'b0;
                  rslt.search_done = 1'b1;
               end else begin
                  in_pass_in        = 1'b1;
                  bit_position_in   = POS_W'(1);
                  last_zero_pos_in  = '0;
                  rslt.send_command = 1'b1;
                  rslt.command_byte = search_command;
               end
            end
         end
         OP_BIT_PAIR: begin
            if (!finished_ff && in_pass_ff) begin
               if (evt.id_bit && evt.cmpl_bit) begin
                  finished_in      = 1'b1;
                  in_pass_in       = 1'b0;
                  rslt.search_done = 1'b1;
                  rslt.bus_error   = 1'b1;
               end else begin
                  if (!evt.id_bit && !evt.cmpl_bit) begin
                     // Discrepancy: follow the old path below the last
                     // mismatch, take the one branch at it, zero beyond.
                     if (bit_position_ff < last_mismatch_ff) begin
                        dir = rom_bits_ff[pos_idx];
                     end else begin
                        dir = (bit_position_ff == last_mismatch_ff);
                     end
                     if (!dir) begin
                        last_zero_pos_in = bit_position_ff;
                     end
                  end else begin
                     dir = evt.id_bit;
                  end
                  rom_bits_in[pos_idx] = dir;
                  rslt.write_valid     = 1'b1;
                  rslt.write_bit       = dir;
                  if (bit_position_ff >= POS_W'(ROM_BITS)) begin
                     rslt.rom_valid     = 1'b1;
                     rslt.found_code    = ROM_CODE_W'(rom_bits_in);
                     rslt.device_number = found_count_ff;
                     found_count_in     = found_count_ff + COUNT_W'(1);
                     last_mismatch_in   = last_zero_pos_in;
                     in_pass_in         = 1'b0;
                     bit_position_in    = POS_W'(1);
                     if (last_zero_pos_in == '0 || found_count_in >= limit) begin
                        finished_in      = 1'b1;
                        rslt.search_done = 1'b1;
                     end
                  end else begin
                     bit_position_in = bit_position_ff + POS_W'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase

      rslt.devices_found = found_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bits_ff      <= '0;
         last_mismatch_ff <= '0;
         last_zero_pos_ff <= '0;
         bit_position_ff  <= POS_W'(1);
         found_count_ff   <= '0;
         finished_ff      <= 1'b1;
         in_pass_ff       <= 1'b0;
      end else if (advance) begin
         rom_bits_ff      <= rom_bits_in;
         last_mismatch_ff <= last_mismatch_in;
         last_zero_pos_ff <= last_zero_pos_in;
         bit_position_ff  <= bit_position_in;
         found_count_ff   <= found_count_in;
         finished_ff      <= finished_in;
         in_pass_ff       <= in_pass_in;
      end
   end

`ifndef SYNTHESIS
   a_finished_not_in_pass: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !in_pass_ff)
      else $error("search finished while a pass is open");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      bit_position_ff != '0 && bit_position_ff <= POS_W'(ROM_BITS))
      else $error("bit position out of range");

   a_bus_error_ends: assert property (@(posedge clock) disable iff (reset)
      advance && rslt.bus_error |-> rslt.search_done && !rslt.write_valid)
      else $error("bus error without end of search");

   a_rom_closes_pass: assert property (@(posedge clock) disable iff (reset)
      advance && rslt.rom_valid |=> !in_pass_ff && bit_position_ff == POS_W'(1))
      else $error("pass still open after a ROM code");

   a_rom_counts: assert property (@(posedge clock) disable iff (reset)
      advance && rslt.rom_valid |=>
         found_count_ff == $past(found_count_ff) + COUNT_W'(1))
      else $error("device count not advanced on a ROM code");
`endif

endmodule

// File: rtl/onewire_rom_search.sv
// The request beat is registered in the input stage when it is accepted, and the
// result register loads from that stage when it advances, held off by an unread result.
// One request beat per cycle unless the output stalls; a request is still taken while one
// result waits to be read, and the output register holds it until rsp.ready.
// Reset (synchronous, active high) clears both stages, sets the search to done
// and loads the register defaults: command 0xF0, device limit 2.
module onewire_rom_search
   import owrs_pkg::*;
#(
   parameter int unsigned ROM_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   owrs_req_if.sink               req,
   owrs_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [CMD_W-1:0]   search_command_ff;
   logic [COUNT_W-1:0] device_limit_ff;

   logic     s1_valid_ff, s1_valid_in;
   evt_type  s1_evt_ff;
   logic     s2_valid_ff, s2_valid_in;
   rslt_type s2_rslt_ff;
   rslt_type rslt;

   logic advance;
   logic take;

   assign advance   = s1_valid_ff && (!s2_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (advance) begin
         s2_valid_in = 1'b1;
      end else if (rsp.ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_evt_ff.op       <= req.op;
         s1_evt_ff.presence <= req.presence;
         s1_evt_ff.id_bit   <= req.id_bit;
         s1_evt_ff.cmpl_bit <= req.cmpl_bit;
      end
      if (advance) begin
         s2_rslt_ff <= rslt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_command_ff <= SEARCH_COMMAND_RESET;
         device_limit_ff   <= DEVICE_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEARCH_COMMAND: search_command_ff <= csr_wdata[CMD_W-1:0];
            CSR_DEVICE_LIMIT:   device_limit_ff   <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   owrs_step #(
      .ROM_BITS (ROM_BITS)
   ) u_step (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .evt            (s1_evt_ff),
      .search_command (search_command_ff),
      .device_limit   (device_limit_ff),
      .rslt           (rslt)
   );

   assign rsp.valid         = s2_valid_ff;
   assign rsp.send_command  = s2_rslt_ff.send_command;
   assign rsp.command_byte  = s2_rslt_ff.command_byte;
   assign rsp.write_valid   = s2_rslt_ff.write_valid;
   assign rsp.write_bit     = s2_rslt_ff.write_bit;
   assign rsp.rom_valid     = s2_rslt_ff.rom_valid;
   assign rsp.found_code    = s2_rslt_ff.found_code;
   assign rsp.device_number = s2_rslt_ff.device_number;
   assign rsp.search_done   = s2_rslt_ff.search_done;
   assign rsp.bus_error     = s2_rslt_ff.bus_error;
   assign rsp.devices_found = s2_rslt_ff.devices_found;

endmodule

// File: test/tb_onewire_rom_search.sv
`timescale 1ns / 1ps

module tb_onewire_rom_search;
   import owrs_pkg::*;

   localparam int unsigned ROM_LEN = 64;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   owrs_req_if req_ch ();
   owrs_rsp_if rsp_ch ();

   onewire_rom_search #(.ROM_BITS(ROM_LEN)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Tracks the search state from the accepted events and checks every result beat.
   class search_tracker;
      logic [ROM_LEN-1:0] rom_image;
      logic [6:0] mismatch_pos;
      logic [6:0] zero_pos;
      logic [6:0] bit_pos;
      logic [7:0] found;
      bit done_flag;
      bit pass_on;
      logic [7:0] cmd_byte;
      logic [7:0] dev_limit;
      bit last_dir;
      rslt_type pending_results[$];
      int unsigned error_count;

      function new();
         rom_image = '0;
         mismatch_pos = '0;
         zero_pos = '0;
         bit_pos = 7'd1;
         found = '0;
         done_flag = 1'b1;
         pass_on = 1'b0;
         cmd_byte = SEARCH_COMMAND_RESET;
         dev_limit = DEVICE_LIMIT_RESET;
         last_dir = 1'b0;
         error_count = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [7:0] value);
         if (idx == CSR_SEARCH_COMMAND) begin
            cmd_byte = value;
         end else begin
            dev_limit = value;
         end
      endfunction

      function bit is_done();
         return done_flag;
      endfunction

      function bit in_pass();
         return pass_on;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      // Returns 1 when the event changed anything, 0 when the block ignores it.
      function bit note_event(logic [1:0] op, bit presence, bit id, bit comp);
         rslt_type beat;
         logic [5:0] slot;
         logic [7:0] lim;
         bit dir;
         bit effective;
         beat = '0;
         effective = 1'b1;
         if (op == OP_BEGIN) begin
            rom_image = '0;
            mismatch_pos = '0;
            zero_pos = '0;
            bit_pos = 7'd1;
            found = '0;
            done_flag = 1'b0;
            pass_on = 1'b0;
         end else if (op == OP_RESET_DONE && !done_flag) begin
            if (!presence) begin
               done_flag = 1'b1;
               pass_on = 1'b0;
               beat.search_done = 1'b1;
            end else begin
               pass_on = 1'b1;
               bit_pos = 7'd1;
               zero_pos = '0;
               beat.send_command = 1'b1;
               beat.command_byte = cmd_byte;
            end
         end else if (op == OP_BIT_PAIR && !done_flag && pass_on) begin
            if (id && comp) begin
               done_flag = 1'b1;
               pass_on = 1'b0;
               beat.search_done = 1'b1;
               beat.bus_error = 1'b1;
            end else begin
               slot = 6'(bit_pos - 7'd1);
               if (!id && !comp) begin
                  // Both branches exist: follow the last pass below the last
                  // discrepancy, take the one branch at it, zero above it.
                  if (bit_pos < mismatch_pos) begin
                     dir = rom_image[slot];
                  end else begin
                     dir = (bit_pos == mismatch_pos);
                  end
                  if (!dir) begin
                     zero_pos = bit_pos;
                  end
               end else begin
                  dir = id;
               end
               rom_image[slot] = dir;
               last_dir = dir;
               beat.write_valid = 1'b1;
               beat.write_bit = dir;
               if (bit_pos >= ROM_LEN) begin
                  beat.rom_valid = 1'b1;
                  beat.found_code = rom_image;
                  beat.device_number = found;
                  found = found + 8'd1;
                  mismatch_pos = zero_pos;
                  pass_on = 1'b0;
                  bit_pos = 7'd1;
                  lim = (dev_limit == 8'd0) ? 8'd1 : dev_limit;
                  if (zero_pos == 7'd0 || found >= lim) begin
                     done_flag = 1'b1;
                     beat.search_done = 1'b1;
                  end
               end else begin
                  bit_pos = bit_pos + 7'd1;
               end
            end
         end else begin
            effective = 1'b0;
         end
         beat.devices_found = found;
         pending_results.push_back(beat);
         return effective;
      endfunction

      function void compare(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
         end
      endfunction

      function void check_result(rslt_type got);
         rslt_type want;
         if (pending_results.size() == 0) begin
            $error("result beat arrived with no event outstanding");
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         compare("send_command", want.send_command, got.send_command);
         compare("command_byte", want.command_byte, got.command_byte);
         compare("write_valid", want.write_valid, got.write_valid);
         compare("write_bit", want.write_bit, got.write_bit);
         compare("rom_valid", want.rom_valid, got.rom_valid);
         compare("found_code", want.found_code, got.found_code);
         compare("device_number", want.device_number, got.device_number);
         compare("search_done", want.search_done, got.search_done);
         compare("bus_error", want.bus_error, got.bus_error);
         compare("devices_found", want.devices_found, got.devices_found);
      endfunction
   endclass

   search_tracker sb = new();

   logic [ROM_LEN-1:0] device_codes[$];
   int unsigned effective_beats = 0;
   int unsigned burst_left = 0;

   always @(posedge clock) begin
      rslt_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.send_command = rsp_ch.send_command;
         got.command_byte = rsp_ch.command_byte;
         got.write_valid = rsp_ch.write_valid;
         got.write_bit = rsp_ch.write_bit;
         got.rom_valid = rsp_ch.rom_valid;
         got.found_code = rsp_ch.found_code;
         got.device_number = rsp_ch.device_number;
         got.search_done = rsp_ch.search_done;
         got.bus_error = rsp_ch.bus_error;
         got.devices_found = rsp_ch.devices_found;
         sb.check_result(got);
      end
   end

   // The result side cycles through always ready, coin flips, a fixed stall
   // pattern and long stalls.
   initial begin
      logic [15:0] tick;
      tick = '0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick = tick + 16'd1;
         case (tick[9:8])
            2'd0: rsp_ch.ready <= 1'b1;
            2'd1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2'd2: rsp_ch.ready <= (tick[3:0] < 4'd11);
            default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   function automatic bit coin();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic send_event(input logic [1:0] op, input bit presence, input bit id,
                             input bit comp);
      int unsigned idle_len;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 20);
         idle_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (idle_len != 0) begin
            req_ch.valid <= 1'b0;
            req_ch.op <= 2'($urandom);
            repeat (idle_len) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.presence <= presence;
      req_ch.id_bit <= id;
      req_ch.cmpl_bit <= comp;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (sb.note_event(op, presence, id, comp)) begin
         effective_beats++;
      end
   endtask

   task automatic settle(input int unsigned tail);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] command, input logic [7:0] limit);
      csr_we <= 1'b1;
      csr_index <= CSR_SEARCH_COMMAND;
      csr_wdata <= command;
      @(posedge clock);
      sb.set_register(CSR_SEARCH_COMMAND, command);
      csr_index <= CSR_DEVICE_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      sb.set_register(CSR_DEVICE_LIMIT, limit);
      csr_we <= 1'b0;
   endtask

   // Builds a bus population; some codes are neighbors that differ in one bit
   // so that discrepancies also fall deep in the code.
   task automatic make_devices(input int unsigned count);
      logic [ROM_LEN-1:0] code;
      int unsigned kind;
      device_codes.delete();
      for (int k = 0; k < count; k++) begin
         kind = $urandom_range(0, 7);
         if (kind == 0) begin
            code = '0;
         end else if (kind == 1) begin
            code = '1;
         end else if (kind < 4 && k > 0) begin
            code = device_codes[$urandom_range(0, k - 1)];
            code[$urandom_range(0, ROM_LEN - 1)] ^= 1'b1;
         end else begin
            code = {$urandom, $urandom};
         end
         device_codes.push_back(code);
      end
   endtask

   // Wired-AND read of a bit and its complement over the devices still on line.
   function automatic void bus_read(input int unsigned pos, input bit [7:0] online,
                                    output bit id, output bit comp);
      id = 1'b1;
      comp = 1'b1;
      foreach (device_codes[k]) begin
         if (online[k]) begin
            if (device_codes[k][pos-1]) comp = 1'b0;
            else id = 1'b0;
         end
      end
   endfunction

   function automatic void drop_devices(input int unsigned pos, inout bit [7:0] online);
      foreach (device_codes[k]) begin
         if (device_codes[k][pos-1] != sb.last_dir) online[k] = 1'b0;
      end
   endfunction

   task automatic run_search();
      int unsigned pos;
      int unsigned passes;
      int unsigned pick;
      bit [7:0] online;
      bit id;
      bit comp;
      make_devices($urandom_range(1, 5));
      send_event(OP_BEGIN, coin(), coin(), coin());
      passes = 0;
      while (!sb.is_done() && passes < 12) begin
         passes++;
         send_event(OP_RESET_DONE, $urandom_range(0, 24) != 0, coin(), coin());
         online = '1;
         pos = 1;
         while (sb.in_pass()) begin
            pick = $urandom_range(0, 299);
            if (pick == 0) begin
               // Bus reset in the middle of a pass starts it over.
               send_event(OP_RESET_DONE, 1'b1, coin(), coin());
               online = '1;
               pos = 1;
            end else if (pick == 1) begin
               send_event(OP_BIT_PAIR, coin(), 1'b1, 1'b1);
            end else if (pick == 2) begin
               send_event(OP_BIT_PAIR, coin(), coin(), coin());
               drop_devices(pos, online);
               pos++;
            end else if (pick == 3) begin
               send_event(OP_UNUSED, coin(), coin(), coin());
            end else if (pick == 4) begin
               send_event(OP_BEGIN, coin(), coin(), coin());
            end else begin
               bus_read(pos, online, id, comp);
               send_event(OP_BIT_PAIR, coin(), id, comp);
               drop_devices(pos, online);
               pos++;
            end
         end
      end
   endtask

   initial begin
      int unsigned quota;
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_BEGIN;
      req_ch.presence <= 1'b0;
      req_ch.id_bit <= 1'b0;
      req_ch.cmpl_bit <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_SEARCH_COMMAND;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset the search counts as done, so the events before the first begin are ignored.
      send_event(OP_BIT_PAIR, 1'b0, 1'b0, 1'b0);
      send_event(OP_RESET_DONE, 1'b1, 1'b0, 1'b0);
      send_event(OP_UNUSED, 1'b1, 1'b1, 1'b1);
      send_event(OP_BEGIN, 1'b0, 1'b0, 1'b0);
      send_event(OP_BIT_PAIR, 1'b1, 1'b0, 1'b1);
      send_event(OP_RESET_DONE, 1'b0, 1'b1, 1'b1);
      send_event(OP_RESET_DONE, 1'b1, 1'b0, 1'b0);
      send_event(OP_BEGIN, 1'b1, 1'b1, 1'b1);
      send_event(OP_RESET_DONE, 1'b1, 1'b0, 1'b0);
      send_event(OP_BIT_PAIR, 1'b0, 1'b0, 1'b1);
      send_event(OP_BIT_PAIR, 1'b0, 1'b1, 1'b0);
      send_event(OP_BIT_PAIR, 1'b0, 1'b0, 1'b0);
      send_event(OP_UNUSED, 1'b0, 1'b0, 1'b0);
      send_event(OP_RESET_DONE, 1'b1, 1'b0, 1'b0);
      send_event(OP_BIT_PAIR, 1'b1, 1'b0, 1'b0);
      send_event(OP_BIT_PAIR, 1'b0, 1'b1, 1'b1);
      send_event(OP_BIT_PAIR, 1'b0, 1'b0, 1'b0);
      send_event(OP_BEGIN, 1'b0, 1'b0, 1'b0);

      for (int ph = 0; ph < 5; ph++) begin
         settle(4);
         case (ph)
            1: write_config(8'h00, 8'd1);
            2: write_config(8'hFF, 8'd255);
            3: write_config(8'hEC, 8'd0);
            4: write_config(8'($urandom), 8'($urandom_range(2, 6)));
            default: ;
         endcase
         quota = effective_beats + 80;
         while (effective_beats < quota) begin
            run_search();
            repeat ($urandom_range(0, 3)) send_event(2'($urandom), coin(), coin(), coin());
         end
      end

      settle(8);
      if (sb.error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/owrs_pkg.sv
rtl/owrs_if.sv
rtl/owrs_step.sv
rtl/onewire_rom_search.sv
test/tb_onewire_rom_search.sv
